### hw/rtl/ascii_unsigned_parser_core_defines.svh
// ----------------------------------------------------------------------------
// ascii_unsigned_parser_core_defines
// Assertion macros shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASCII_UNSIGNED_PARSER_CORE_DEFINES_SVH
`define ASCII_UNSIGNED_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AUP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aup assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define AUP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aup assertion failed");

`endif

### hw/rtl/aup_pkg.sv
// ----------------------------------------------------------------------------
// aup_pkg
// Widths, character codes and the classified-character type of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aup_pkg;

  // Width of the accumulator; the value port is always 64 bits.
  localparam int VALUE_BITS = 64;
  localparam int VALUE_W    = 64;
  localparam int COUNT_W    = 16;
  localparam int RADIX_W    = 6;
  localparam int CH_W       = 8;
  localparam int DIGIT_W    = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

  // Character codes.
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;

  // Bases.
  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One character after classification.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;     // Digit value, or DIGIT_NONE.
    logic               blank;     // Space or tab.
    logic               zero;      // The character '0'.
    logic               hex_mark;  // 'x' or 'X'.
  } entry_t;

endpackage

`default_nettype wire

### hw/rtl/aup_if.sv
// ----------------------------------------------------------------------------
// aup_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
`default_nettype none

// Character channel.
interface aup_char_if import aup_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// Result channel.
interface aup_res_if import aup_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] end_offset;

  modport source (output valid, output value, output end_offset, input ready);
  modport sink   (input valid, input value, input end_offset, output ready);
endinterface

`default_nettype wire

### hw/rtl/aup_front.sv
// ----------------------------------------------------------------------------
// aup_front
// Accepts characters and classifies them into digit value and marker flags.
// ----------------------------------------------------------------------------
`default_nettype none

module aup_front import aup_pkg::*; (
  aup_char_if.sink chars,
  input  wire logic q_full,
  output logic      push,
  output entry_t    entry
);

  // A character is taken whenever the queue has room.
  assign chars.ready = !q_full;
  assign push        = chars.valid && !q_full;

  // Digit decode for 0-9, a-f and A-F.
  always_comb begin
    entry = '0;
    if (chars.ch >= CH_ZERO && chars.ch <= CH_NINE) begin
      entry.digit = DIGIT_W'(chars.ch - CH_ZERO);
    end else if (chars.ch >= CH_LA && chars.ch <= CH_LF) begin
      entry.digit = DIGIT_W'(chars.ch - CH_LA + 8'd10);
    end else if (chars.ch >= CH_UA && chars.ch <= CH_UF) begin
      entry.digit = DIGIT_W'(chars.ch - CH_UA + 8'd10);
    end else begin
      entry.digit = DIGIT_NONE;
    end
    entry.blank    = (chars.ch == CH_SPACE) || (chars.ch == CH_TAB);
    entry.zero     = (chars.ch == CH_ZERO);
    entry.hex_mark = (chars.ch == CH_LX) || (chars.ch == CH_UX);
  end

endmodule

`default_nettype wire

### hw/rtl/aup_queue.sv
// ----------------------------------------------------------------------------
// aup_queue
// Short register FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ascii_unsigned_parser_core_defines.svh"

module aup_queue import aup_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        not_empty,
  output entry_t      head
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  // The queue reports full during reset so that no character is taken then.
  assign full      = rst || (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `AUP_ASSERT_IMPL(q_no_underflow, pop, count != '0)
  `AUP_ASSERT_NEXT(q_push_fills, push && !pop, count != '0)

endmodule

`default_nettype wire

### hw/rtl/aup_back.sv
// ----------------------------------------------------------------------------
// aup_back
// Runs the parse state machine on classified characters and registers results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ascii_unsigned_parser_core_defines.svh"

module aup_back import aup_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [RADIX_W-1:0] radix,
  input  wire logic               q_not_empty,
  input  wire entry_t             head,
  output logic                    pop,
  aup_res_if.source               results
);

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  phase_t                phase, phase_next;
  logic [VALUE_BITS-1:0] accum, accum_next;
  logic [RADIX_W-1:0]    work_base, base_next;
  logic [COUNT_W-1:0]    char_count, count_next, count_inc;
  logic                  take;
  logic [RADIX_W-1:0]    take_base;
  logic                  ends;
  logic [VALUE_BITS+RADIX_W-1:0] mac;

  assign count_inc = (char_count == COUNT_MAX) ? char_count : char_count + 1'b1;
  assign mac = accum * take_base + (VALUE_BITS + RADIX_W)'(head.digit);

  // Next-state decode for the character at the queue head.
  always_comb begin
    phase_next = phase;
    accum_next = accum;
    base_next  = work_base;
    count_next = char_count;
    take       = 1'b0;
    take_base  = work_base;
    ends       = 1'b0;
    unique case (phase)
      PH_SPACE: begin
        if (head.blank) begin
          count_next = count_inc;
        end else if (head.zero && (radix == BASE_AUTO || radix == BASE_HEX)) begin
          base_next  = radix;
          accum_next = '0;
          count_next = count_inc;
          phase_next = PH_ZERO;
        end else begin
          take      = 1'b1;
          take_base = (radix == BASE_AUTO) ? BASE_DEC : radix;
        end
      end
      PH_ZERO: begin
        if (head.hex_mark) begin
          base_next  = BASE_HEX;
          count_next = count_inc;
          phase_next = PH_DIGITS;
        end else begin
          take      = 1'b1;
          take_base = (work_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        end
      end
      // Digits phase; the unused code behaves the same.
      default: begin
        take      = 1'b1;
        take_base = work_base;
      end
    endcase
    if (take) begin
      if (head.digit == DIGIT_NONE || RADIX_W'(head.digit) >= take_base) begin
        ends       = 1'b1;
        phase_next = PH_SPACE;
        accum_next = '0;
        base_next  = '0;
        count_next = '0;
      end else begin
        accum_next = VALUE_BITS'(mac);
        base_next  = take_base;
        count_next = count_inc;
        phase_next = PH_DIGITS;
      end
    end
  end

  // A terminator waits only while the output register holds a result that is not being taken.
  assign pop = q_not_empty && (!ends || !results.valid || results.ready);

  // Parse state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SPACE;
      accum         <= '0;
      work_base     <= '0;
      char_count    <= '0;
      results.valid <= 1'b0;
    end else begin
      if (pop && ends) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      if (pop) begin
        phase      <= phase_next;
        accum      <= accum_next;
        work_base  <= base_next;
        char_count <= count_next;
        if (ends) begin
          results.value      <= VALUE_W'(accum);
          results.end_offset <= char_count;
        end
      end
    end
  end

  `AUP_ASSERT_IMPL(bk_idle_after_result, $rose(results.valid),
                   phase == PH_SPACE && char_count == '0)
  `AUP_ASSERT_IMPL(bk_digits_have_base, phase == PH_DIGITS, work_base != '0)

endmodule

`default_nettype wire

### hw/rtl/ascii_unsigned_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_unsigned_parser_core
// Streaming unsigned ASCII integer parser, one character per transaction.
//
//   channel   dir   payload                        handshake
//   chars     in    ch[7:0]                        valid/ready
//   results   out   value[63:0], end_offset[15:0]  valid/ready
//   radix     in    radix_wdata[5:0]               radix_we, no wait
//
// One character is accepted per cycle while the queue has room; a result is
// registered in the cycle after its terminator is taken from the queue. Each
// accepted character passes through the queue to the back stage, whose
// per-character step is one 64x6 multiply-add. The two-entry queue lets the
// front keep accepting while a result waits in the output register. Reset is
// synchronous and clears state, queue and radix (auto-detect).
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_unsigned_parser_core import aup_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  aup_char_if.sink                chars,
  aup_res_if.source               results,
  input  wire logic               radix_we,
  input  wire logic [RADIX_W-1:0] radix_wdata
);

  logic [RADIX_W-1:0] radix;
  logic               q_full;
  logic               q_not_empty;
  logic               push;
  logic               pop;
  entry_t             in_entry;
  entry_t             head;

  // Radix register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= BASE_AUTO;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  aup_front u_front (
    .chars  (chars),
    .q_full (q_full),
    .push   (push),
    .entry  (in_entry)
  );

  aup_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (in_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  aup_back u_back (
    .clk         (clk),
    .rst         (rst),
    .radix       (radix),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .results     (results)
  );

endmodule

`default_nettype wire
